// File: hw/rtl/plsa_pkg.sv
package plsa_pkg;

    localparam int POOLS      = 16;
    localparam int MAX_LAYERS = 64;
    localparam int POOL_W     = 4;
    localparam int LAYER_W    = 6;
    localparam int REQ_W      = 3;
    localparam int STATUS_W   = 3;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    // request codes
    localparam logic [REQ_W-1:0] REQ_RESERVE = 3'd0;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CHECK   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CREATE  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DESTROY = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_LAYER = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_COUNT = 3'd5;

    // first field in the highest bits
    typedef struct packed {
        logic [LAYER_W-1:0] layer_count;
        logic [LAYER_W-1:0] layer_index;
        logic [POOL_W-1:0]  pool_sel;
        logic [REQ_W-1:0]   req_type;
    } t_req;

    typedef struct packed {
        logic               in_use;
        logic [LAYER_W-1:0] granted_layer;
        logic [STATUS_W-1:0] status;
    } t_res;

    localparam int REQ_BITS = $bits(t_req);
    localparam int RES_BITS = $bits(t_res);

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

// File: hw/rtl/plsa_ctrl.sv
module plsa_ctrl import plsa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_tvalid,
    output logic  o_in_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    assign o_in_tready = (r_state == S_IDLE);

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                // wait until the result register can take the result
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hw/rtl/plsa_dpath.sv
module plsa_dpath import plsa_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    input  logic [IN_TDATA_W-1:0]  i_in_tdata,
    input  logic                   i_out_tready,
    output logic                   o_out_tvalid,
    output logic [OUT_TDATA_W-1:0] o_out_tdata
);

    t_req                    w_in_req;
    t_req                    r_req;
    logic [MAX_LAYERS-1:0]   r_bitmap_mem [POOLS];
    logic [MAX_LAYERS-1:0]   r_rd_data;
    logic [POOLS-1:0]        r_present;
    logic [LAYER_W-1:0]      r_count [POOLS];
    logic                    r_out_valid;
    t_res                    r_out_data;

    logic                    w_present;
    logic [LAYER_W-1:0]      w_count;
    logic                    w_in_range;
    logic [MAX_LAYERS-1:0]   w_avail;
    logic                    w_found;
    logic [LAYER_W-1:0]      w_free_idx;
    logic                    w_count_ok;
    logic                    w_create_ok;
    logic                    w_destroy;
    logic                    w_we;
    logic [MAX_LAYERS-1:0]   w_wdata;
    t_res                    w_res;

    assign w_in_req = t_req'(i_in_tdata[REQ_BITS-1:0]);

    assign w_present  = r_present[r_req.pool_sel];
    assign w_count    = r_count[r_req.pool_sel];
    assign w_in_range = r_req.layer_index < w_count;
    assign w_count_ok = (r_req.layer_count != '0) &&
                        ({1'b0, r_req.layer_count} < (LAYER_W+1)'(MAX_LAYERS));

    // free layers below the pool's layer count
    always_comb begin
        for (int i = 0; i < MAX_LAYERS; i++) begin
            w_avail[i] = !r_rd_data[i] && (LAYER_W'(i) < w_count);
        end
    end

    // lowest free layer
    always_comb begin
        w_free_idx = '0;
        for (int i = MAX_LAYERS - 1; i >= 0; i--) begin
            if (w_avail[i]) begin
                w_free_idx = LAYER_W'(i);
            end
        end
    end

    assign w_found = |w_avail;

    always_comb begin
        w_res       = '0;
        w_res.status = ST_OK;
        w_we        = 1'b0;
        w_wdata     = r_rd_data;
        w_create_ok = 1'b0;
        w_destroy   = 1'b0;
        case (r_req.req_type)
            REQ_RESERVE: begin
                if (!w_present) begin
                    w_res.status = ST_MISSING;
                end else if (!w_found) begin
                    w_res.status = ST_FULL;
                end else begin
                    w_res.granted_layer     = w_free_idx;
                    w_we                    = 1'b1;
                    w_wdata[w_free_idx]     = 1'b1;
                end
            end
            REQ_RELEASE: begin
                if (!w_present) begin
                    w_res.status = ST_MISSING;
                end else if (!w_in_range) begin
                    w_res.status = ST_BAD_LAYER;
                end else begin
                    w_we                     = 1'b1;
                    w_wdata[r_req.layer_index] = 1'b0;
                end
            end
            REQ_CHECK: begin
                w_res.in_use = w_present && w_in_range && r_rd_data[r_req.layer_index];
            end
            REQ_CREATE: begin
                if (w_present) begin
                    w_res.status = ST_EXISTS;
                end else if (!w_count_ok) begin
                    w_res.status = ST_BAD_COUNT;
                end else begin
                    w_create_ok = 1'b1;
                    w_we        = 1'b1;
                    w_wdata     = '0;
                end
            end
            REQ_DESTROY: begin
                w_destroy = 1'b1;
            end
            default: begin
                w_res = '0;
            end
        endcase
    end

    assign o_stat.out_free = !r_out_valid || i_out_tready;
    assign o_out_tvalid    = r_out_valid;
    assign o_out_tdata     = OUT_TDATA_W'(r_out_data);

    // bitmap store, contents matter only while the pool is present
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_we) begin
            r_bitmap_mem[r_req.pool_sel] <= w_wdata;
        end
        if (i_cmd.capture) begin
            r_rd_data <= r_bitmap_mem[w_in_req.pool_sel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= w_in_req;
        end
        if (i_cmd.commit) begin
            r_out_data <= w_res;
        end
        if (i_cmd.commit && w_create_ok) begin
            r_count[r_req.pool_sel] <= r_req.layer_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit && w_create_ok) begin
                r_present[r_req.pool_sel] <= 1'b1;
            end else if (i_cmd.commit && w_destroy) begin
                r_present[r_req.pool_sel] <= 1'b0;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: hw/rtl/pooled_layer_slot_allocator_top.sv
// Pooled layer slot allocator: 16 pools, each with up to 63 layers tracked in
// a used bitmap. Every request transfer yields exactly one result transfer.
// A request first reads the pool's bitmap from the bitmap memory into a register,
// then searches for the lowest free layer, writes the bitmap back and loads the
// result register. The next request is taken while the result still waits
// downstream; a result register that stays full holds the block in its execute
// state. No clearing pass runs after reset: pool create clears the bitmap, and a
// pool that is not present never uses what its bitmap holds.
module pooled_layer_slot_allocator_top import plsa_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // req_type[2:0], pool_sel[6:3], layer_index[12:7], layer_count[18:13]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // status[2:0], granted_layer[8:3], in_use[9]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    t_cmd  w_cmd;
    t_stat w_stat;

    plsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_tvalid (i_s_axis_tvalid),
        .o_in_tready (o_s_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    plsa_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_in_tdata   (i_s_axis_tdata),
        .i_out_tready (i_m_axis_tready),
        .o_out_tvalid (o_m_axis_tvalid),
        .o_out_tdata  (o_m_axis_tdata)
    );

endmodule

// File: hw/rtl/plsa_checker.sv
module plsa_checker import plsa_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    logic [STATUS_W-1:0] w_status;
    logic [LAYER_W-1:0]  w_granted;
    logic                w_in_use;

    assign w_status  = o_m_axis_tdata[STATUS_W-1:0];
    assign w_granted = o_m_axis_tdata[STATUS_W+LAYER_W-1:STATUS_W];
    assign w_in_use  = o_m_axis_tdata[STATUS_W+LAYER_W];

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // one request in flight: ready drops after each input transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("request taken while another is in flight");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_status == ST_OK || w_status == ST_MISSING ||
                             w_status == ST_FULL || w_status == ST_BAD_LAYER ||
                             w_status == ST_EXISTS || w_status == ST_BAD_COUNT))
        else $error("status code out of range");

    // a failed request carries no grant and no in-use flag
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (w_status != ST_OK) |-> (w_granted == '0) && !w_in_use)
        else $error("error result carries payload");

endmodule

bind pooled_layer_slot_allocator_top plsa_checker u_plsa_checker (.*);

// File: sim/tb.sv
`timescale 1ns / 100ps

import plsa_pkg::*;

class alloc_scoreboard;
    bit                  present [POOLS];
    logic [LAYER_W-1:0]  layer_cnt [POOLS];
    logic [63:0]         used_map [POOLS];
    t_res                awaiting_results[$];
    int                  errors;

    function new();
        for (int p = 0; p < POOLS; p++) begin
            present[p]   = 1'b0;
            layer_cnt[p] = '0;
            used_map[p]  = '0;
        end
        errors = 0;
    endfunction

    // update the pool state for one accepted request and queue its result
    function void note_request(t_req r);
        t_res want;
        int   p;
        want = '0;
        p = int'(r.pool_sel);
        case (r.req_type)
            REQ_RESERVE: begin
                if (!present[p]) begin
                    want.status = ST_MISSING;
                end else begin
                    want.status = ST_FULL;
                    for (int i = 0; i < layer_cnt[p]; i++) begin
                        if (!used_map[p][i]) begin
                            used_map[p][i]     = 1'b1;
                            want.granted_layer = LAYER_W'(i);
                            want.status        = ST_OK;
                            break;
                        end
                    end
                end
            end
            REQ_RELEASE: begin
                if (!present[p])
                    want.status = ST_MISSING;
                else if (r.layer_index >= layer_cnt[p])
                    want.status = ST_BAD_LAYER;
                else
                    used_map[p][r.layer_index] = 1'b0;
            end
            REQ_CHECK: begin
                if (present[p] && r.layer_index < layer_cnt[p])
                    want.in_use = used_map[p][r.layer_index];
            end
            REQ_CREATE: begin
                if (present[p]) begin
                    want.status = ST_EXISTS;
                end else if (r.layer_count == 0 || r.layer_count >= MAX_LAYERS) begin
                    want.status = ST_BAD_COUNT;
                end else begin
                    present[p]   = 1'b1;
                    layer_cnt[p] = r.layer_count;
                    used_map[p]  = '0;
                end
            end
            REQ_DESTROY: begin
                present[p]   = 1'b0;
                layer_cnt[p] = '0;
                used_map[p]  = '0;
            end
            default: ;
        endcase
        awaiting_results = {awaiting_results, want};
    endfunction

    function void check_result(t_res got);
        t_res want;
        if (awaiting_results.size() == 0) begin
            $display("%0t: result with none expected: status=%0d granted=%0d in_use=%0d",
                     $time, got.status, got.granted_layer, got.in_use);
            errors++;
            return;
        end
        want = awaiting_results.pop_front();
        if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
        end
        if (got.granted_layer !== want.granted_layer) begin
            $display("%0t: granted_layer expected %0d actual %0d",
                     $time, want.granted_layer, got.granted_layer);
            errors++;
        end
        if (got.in_use !== want.in_use) begin
            $display("%0t: in_use expected %0d actual %0d", $time, want.in_use, got.in_use);
            errors++;
        end
    endfunction
endclass

module tb;

    localparam int                N_RANDOM     = 1950;
    localparam logic [REQ_W-1:0]  REQ_TOP_CODE = '1;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    alloc_scoreboard sb = new();
    int burst_left = 0;
    int sent = 0;

    pooled_layer_slot_allocator_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic t_req make_req(logic [REQ_W-1:0] kind, int pool, int layer, int cnt);
        t_req r;
        r.req_type    = kind;
        r.pool_sel    = POOL_W'(pool);
        r.layer_index = LAYER_W'(layer);
        r.layer_count = LAYER_W'(cnt);
        return r;
    endfunction

    // sender works in bursts, with an idle gap, sometimes none, before each new burst
    task automatic send_request(input t_req r);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                i_s_axis_tvalid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = IN_TDATA_W'(r);
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_request(r);
        sent++;
    endtask

    function automatic int pick_pool();
        return ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(0, POOLS - 1);
    endfunction

    function automatic int pick_layer();
        return ($urandom_range(0, 4) != 0) ? $urandom_range(0, 9) : $urandom_range(0, 63);
    endfunction

    function automatic int pick_count();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7)
            return $urandom_range(1, 8);
        else if (roll == 7)
            return MAX_LAYERS - 1;
        else if (roll == 8)
            return $urandom_range(1, MAX_LAYERS - 1);
        else
            return ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 63);
    endfunction

    function automatic t_req random_req();
        int   roll;
        t_req r;
        roll = $urandom_range(0, 99);
        r = make_req(REQ_RESERVE, pick_pool(), $urandom_range(0, 63), $urandom_range(0, 63));
        if (roll < 35) begin
            r.req_type = REQ_RESERVE;
        end else if (roll < 55) begin
            r.req_type    = REQ_RELEASE;
            r.layer_index = LAYER_W'(pick_layer());
        end else if (roll < 70) begin
            r.req_type    = REQ_CHECK;
            r.layer_index = LAYER_W'(pick_layer());
        end else if (roll < 88) begin
            r.req_type    = REQ_CREATE;
            r.layer_count = LAYER_W'(pick_count());
        end else if (roll < 96) begin
            r.req_type = REQ_DESTROY;
        end else begin
            r.req_type = REQ_W'($urandom_range(REQ_DESTROY + 1, REQ_TOP_CODE));
        end
        return r;
    endfunction

    // receiver: randomly chosen stretches of always ready, random stalls and long stalls
    initial begin
        int mode;
        int seg;
        i_m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            mode = $urandom_range(0, 2);
            seg  = $urandom_range(20, 200);
            while (seg > 0) begin
                @(negedge i_clk);
                seg--;
                case (mode)
                    0: i_m_axis_tready = 1'b1;
                    1: i_m_axis_tready = ($urandom_range(0, 9) >= 3);
                    default: begin
                        if (i_m_axis_tready) begin
                            if ($urandom_range(0, 3) == 0)
                                i_m_axis_tready = 1'b0;
                        end else if ($urandom_range(0, 5) == 0) begin
                            i_m_axis_tready = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(t_res'(o_m_axis_tdata[RES_BITS-1:0]));
    end

    initial begin
        int   pool;
        t_req r;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_request(make_req(REQ_CREATE,  0, 0, 1));
        send_request(make_req(REQ_RESERVE, 0, 0, 0));
        send_request(make_req(REQ_RESERVE, 0, 0, 0));      // single-layer pool now full
        send_request(make_req(REQ_CHECK,   0, 0, 0));
        send_request(make_req(REQ_CHECK,   0, 63, 0));     // layer beyond count
        send_request(make_req(REQ_RELEASE, 0, 1, 0));
        send_request(make_req(REQ_RELEASE, 0, 0, 0));
        send_request(make_req(REQ_RELEASE, 0, 0, 0));      // layer already free
        send_request(make_req(REQ_CREATE,  0, 0, 5));      // pool already there
        send_request(make_req(REQ_CREATE,  15, 0, 0));
        send_request(make_req(REQ_CREATE,  15, 0, 63));
        send_request(make_req(REQ_RESERVE, 15, 0, 0));
        send_request(make_req(REQ_RESERVE, 15, 0, 0));
        send_request(make_req(REQ_CHECK,   15, 62, 0));
        send_request(make_req(REQ_RELEASE, 15, 63, 0));
        send_request(make_req(REQ_DESTROY, 0, 0, 0));
        send_request(make_req(REQ_RESERVE, 0, 0, 0));
        send_request(make_req(REQ_RELEASE, 0, 0, 0));
        send_request(make_req(REQ_CHECK,   0, 0, 0));
        send_request(make_req(REQ_DESTROY, 0, 0, 0));      // pool not present
        send_request(make_req(REQ_TOP_CODE, 15, 63, 63));
        send_request(make_req(REQ_W'(REQ_DESTROY + 1), 7, 21, 42));
        send_request(make_req(REQ_W'(REQ_TOP_CODE - 1), 9, 42, 21));
        send_request(make_req(REQ_DESTROY, 15, 63, 63));

        sent = 0;
        while (sent < N_RANDOM) begin
            if ($urandom_range(0, 79) == 0) begin
                // drive one pool to full, then free a few layers
                pool = pick_pool();
                repeat ($urandom_range(MAX_LAYERS - 8, MAX_LAYERS + 2))
                    send_request(make_req(REQ_RESERVE, pool, $urandom_range(0, 63),
                                          $urandom_range(0, 63)));
                repeat ($urandom_range(1, 4))
                    send_request(make_req(REQ_RELEASE, pool, $urandom_range(0, 63), 0));
            end else begin
                r = random_req();
                send_request(r);
            end
        end

        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (sb.awaiting_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (sb.errors == 0 && sb.awaiting_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
